// File: src/jpcu_pkg.sv
// Package for the JVM primitive conversion unit: command codes and stage payload types.
// No dependencies.
`default_nettype none
package jpcu_pkg;
    localparam logic [2:0] CMD_I2L = 3'd0;
    localparam logic [2:0] CMD_I2F = 3'd1;
    localparam logic [2:0] CMD_F2I = 3'd2;
    localparam logic [2:0] CMD_I2B = 3'd3;
    localparam logic [2:0] CMD_I2C = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] operand;
        logic        sign;
        logic [31:0] mag;
    } s1_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] operand;
        logic        sign;
        logic [31:0] norm;
        logic [4:0]  top;
        logic        zero;
    } s2_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        result_wide;
    } res_t;
endpackage
`default_nettype wire

// File: src/jvm_primitive_conversion_unit.sv
// Top level of the JVM primitive conversion unit: three-stage pipeline.
// Throughput is one word per cycle while m_axis_tready keeps the output moving.
// Stalls propagate per stage, so gaps in the pipeline are filled while the output waits.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
// Depends on jpcu_pkg, jpcu_front and jpcu_back.
`default_nettype none
module jvm_primitive_conversion_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,  // command[2:0], operand_bits[34:3], zero fill
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,  // result_bits[63:0]
    output logic        m_axis_tuser   // result_wide
);
    import jpcu_pkg::*;
    logic v1, v2, v3;
    logic adv1, adv2, adv3;
    s2_t  s2;
    res_t res;

    assign adv3 = !v3 || m_axis_tready;
    assign adv2 = !v2 || adv3;
    assign adv1 = !v1 || adv2;
    assign s_axis_tready = adv1;

    jpcu_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid),
        .in_command(s_axis_tdata[2:0]), .in_operand(s_axis_tdata[34:3]),
        .adv1(adv1), .adv2(adv2), .v1_reg(v1), .v2_reg(v2), .s2_reg(s2)
    );

    jpcu_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(v2), .s2(s2), .adv3(adv3),
        .v3_reg(v3), .res_reg(res)
    );

    assign m_axis_tvalid = v3;
    assign m_axis_tdata  = res.result_bits;
    assign m_axis_tuser  = res.result_wide;
endmodule
`default_nettype wire

// File: src/jpcu_front.sv
// Front stages: magnitude, then normalization by leading-one position.
// Depends on jpcu_pkg.
`default_nettype none
module jpcu_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    input  wire [2:0]         in_command,
    input  wire [31:0]        in_operand,
    input  wire               adv1,
    input  wire               adv2,
    output logic              v1_reg,
    output logic              v2_reg,
    output jpcu_pkg::s2_t     s2_reg
);
    import jpcu_pkg::*;
    s1_t s1_reg;
    s1_t s1_next;
    s2_t s2_next;
    logic [4:0] lz;

    always_comb
    begin
        s1_next.command = in_command;
        s1_next.operand = in_operand;
        s1_next.sign    = in_operand[31];
        s1_next.mag     = in_operand[31] ? (32'd0 - in_operand) : in_operand;
    end

    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (s1_reg.mag[i])
            begin
                lz = 5'(i);
            end
        end
        s2_next.command = s1_reg.command;
        s2_next.operand = s1_reg.operand;
        s2_next.sign    = s1_reg.sign;
        s2_next.top     = lz;
        s2_next.zero    = (s1_reg.mag == 32'd0);
        s2_next.norm    = s1_reg.mag << (5'd31 - lz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
    end
endmodule
`default_nettype wire

// File: src/jpcu_back.sv
// Final stage: int to float with rounding, float to int by truncation, and simple extensions.
// Depends on jpcu_pkg.
`default_nettype none
module jpcu_back (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    input  jpcu_pkg::s2_t    s2,
    input  wire              adv3,
    output logic             v3_reg,
    output jpcu_pkg::res_t   res_reg
);
    import jpcu_pkg::*;
    res_t res_next;
    logic [24:0] mant;
    logic [7:0]  fexp;
    logic        rnd;
    logic [31:0] fbits;
    logic [7:0]  ex;
    logic [22:0] frac;
    logic [7:0]  e;
    logic [55:0] wide_m;
    logic [31:0] val;
    logic [31:0] ibits;

    always_comb
    begin
        rnd  = s2.norm[7] & (s2.norm[8] | (s2.norm[6:0] != 7'd0));
        mant = {1'b0, s2.norm[31:8]} + 25'(rnd);
        fexp = 8'(s2.top) + 8'd127 + 8'(mant[24]);
        fbits = s2.zero ? 32'd0 : {s2.sign, fexp, mant[24] ? mant[23:1] : mant[22:0]};

        ex   = s2.operand[30:23];
        frac = s2.operand[22:0];
        e    = ex - 8'd127;
        wide_m = {32'd0, 1'b1, frac} << e[4:0];
        val  = wide_m[54:23];
        if (ex == 8'hFF && frac != 23'd0)
        begin
            ibits = 32'd0;
        end
        else if (ex < 8'd127)
        begin
            ibits = 32'd0;
        end
        else if (e >= 8'd31)
        begin
            ibits = s2.operand[31] ? 32'h80000000 : 32'h7FFFFFFF;
        end
        else
        begin
            ibits = s2.operand[31] ? (32'd0 - val) : val;
        end

        res_next.result_wide = 1'b0;
        unique case (s2.command)
            CMD_I2L:
            begin
                res_next.result_bits = {{32{s2.operand[31]}}, s2.operand};
                res_next.result_wide = 1'b1;
            end
            CMD_I2F: res_next.result_bits = {32'd0, fbits};
            CMD_F2I: res_next.result_bits = {32'd0, ibits};
            CMD_I2B: res_next.result_bits = {32'd0, {24{s2.operand[7]}}, s2.operand[7:0]};
            CMD_I2C: res_next.result_bits = {48'd0, s2.operand[15:0]};
            default: res_next.result_bits = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv3)
        begin
            v3_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            res_reg <= res_next;
        end
    end
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the JVM primitive conversion unit: directed and random conversion words
// checked against a built-in predictor, with random idling and a long output hold-off.
// Depends on jpcu_pkg and the jvm_primitive_conversion_unit RTL.
`default_nettype none
module tb_top;
    import jpcu_pkg::*;

    typedef struct packed {
        logic [63:0] bits;
        logic        wide;
    } conv_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    conv_t       pending_results[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          errors;
    int          words_sent;
    int          words_checked;
    int          quiet_cycles;

    jvm_primitive_conversion_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] int_to_float(logic [31:0] x);
        logic        sgn;
        logic [31:0] mag;
        logic [31:0] mant;
        logic [31:0] rem;
        logic [31:0] half;
        int          msb;
        int          sh;
        sgn = x[31];
        mag = sgn ? -x : x;
        if (mag == 0)
            return 32'd0;
        msb = 0;
        for (int i = 0; i < 32; i++)
            if (mag[i])
                msb = i;
        if (msb <= 23)
            mant = mag << (23 - msb);
        else
        begin
            sh = msb - 23;
            rem = mag & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0]))
                mant = mant + 1;
            if (mant == 32'h0100_0000)
            begin
                mant = mant >> 1;
                msb = msb + 1;
            end
        end
        return {sgn, 8'(msb + 127), mant[22:0]};
    endfunction

    function automatic logic [31:0] float_to_int(logic [31:0] b);
        logic [7:0]  ex;
        logic [31:0] m;
        logic [31:0] val;
        int          e;
        ex = b[30:23];
        if (ex == 8'hFF && b[22:0] != 0)
            return 32'd0;
        if (ex < 127)
            return 32'd0;
        e = ex - 127;
        if (e >= 31)
            return b[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        m = {9'd1, b[22:0]};
        val = (e >= 23) ? (m << (e - 23)) : (m >> (23 - e));
        return b[31] ? -val : val;
    endfunction

    function automatic conv_t predict_conversion(logic [2:0] cmd, logic [31:0] op);
        conv_t r;
        r = '0;
        case (cmd)
            CMD_I2L:
            begin
                r.bits = {{32{op[31]}}, op};
                r.wide = 1'b1;
            end
            CMD_I2F: r.bits = {32'd0, int_to_float(op)};
            CMD_F2I: r.bits = {32'd0, float_to_int(op)};
            CMD_I2B: r.bits = {32'd0, {24{op[7]}}, op[7:0]};
            CMD_I2C: r.bits = {48'd0, op[15:0]};
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic send_word(logic [2:0] cmd, logic [31:0] op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, op, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_conversion(cmd, op));
        words_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation: bits=%h", m_axis_tdata);
                errors++;
            end
            else
            begin
                conv_t exp_r;
                exp_r = pending_results.pop_front();
                if (m_axis_tdata !== exp_r.bits)
                begin
                    $error("result_bits expected %h actual %h", exp_r.bits, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== exp_r.wide)
                begin
                    $error("result_wide expected %b actual %b", exp_r.wide, m_axis_tuser);
                    errors++;
                end
                words_checked++;
            end
        end
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic test_integer_extremes;
        logic [31:0] vals[8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h0000_0080, 32'h0000_FF7F, 32'hAAAA_5555};
        foreach (vals[i])
        begin
            send_word(CMD_I2L, vals[i]);
            send_word(CMD_I2B, vals[i]);
            send_word(CMD_I2C, vals[i]);
        end
    endtask

    task automatic test_int_to_float_rounding;
        send_word(CMD_I2F, 32'h0);
        send_word(CMD_I2F, 32'h8000_0000);
        send_word(CMD_I2F, 32'h7FFF_FFFF);
        send_word(CMD_I2F, 32'h0100_0001);
        send_word(CMD_I2F, 32'h0100_0003);
        send_word(CMD_I2F, 32'hFEFF_FFFF);
    endtask

    task automatic test_float_to_int_specials;
        send_word(CMD_F2I, 32'h7FC0_0000);
        send_word(CMD_F2I, 32'h7F80_0000);
        send_word(CMD_F2I, 32'hFF80_0000);
        send_word(CMD_F2I, 32'h4F00_0000);
        send_word(CMD_F2I, 32'hCF00_0000);
        send_word(CMD_F2I, 32'h0000_0001);
        send_word(CMD_F2I, 32'h8000_0000);
        send_word(CMD_F2I, 32'hBFBF_FFFF);
        send_word(CMD_F2I, 32'h4B7F_FFFF);
    endtask

    task automatic test_unused_commands;
        send_word(3'd5, 32'hFFFF_FFFF);
        send_word(3'd6, 32'h1234_5678);
        send_word(3'd7, 32'h8000_0001);
    endtask

    task automatic test_random_words(int count);
        logic [2:0]  cmd;
        logic [31:0] op;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                            : 3'($urandom_range(4));
            op = $urandom;
            if (cmd == CMD_F2I && $urandom_range(2) != 0)
                op = {op[31], 8'($urandom_range(158, 110)), op[22:0]};
            send_word(cmd, op);
        end
    endtask

    task automatic test_output_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (40) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random_words(20);
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        hold_off = 1'b0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_integer_extremes();
        test_int_to_float_rounding();
        test_float_to_int_specials();
        test_unused_commands();
        drain();

        send_idle_pct = 8;
        recv_idle_pct = 84;
        test_random_words(150);
        drain();
        send_idle_pct = 84;
        recv_idle_pct = 8;
        test_random_words(150);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_random_words(130);
        drain();

        $display("Covered %0d words over all commands, float specials and unused codes;",
                 words_sent);
        $display("%0d results checked under idling and a long output stall.", words_checked);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
src/jpcu_pkg.sv
src/jpcu_front.sv
src/jpcu_back.sv
src/jvm_primitive_conversion_unit.sv
verif/tb_top.sv
